// File: rtl/elr_pkg.sv
`default_nettype none

package elr_pkg;

    // default field widths
    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    // item action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // index of the fourth mirrored pixel of a step
    localparam logic [1:0] LAST_PIXEL = 2'd3;

    // walk phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_REGION1 = 2'd1,
        PH_REGION2 = 2'd2
    } phase_t;

    // step engine sequencer
    typedef enum logic [4:0] {
        S_IDLE,
        S_LA,
        S_LB,
        S_LC,
        S_LD,
        S_BX,
        S_AY,
        S_EVAL,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_T5,
        S_T6,
        S_STEP,
        S_M1,
        S_M2,
        S_ACC,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/elr_if.sv
`default_nettype none

// command channel: one start or advance item per transfer
interface elr_in_if
    import elr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius_x;
    logic        [RADIUS_BITS-1:0] radius_y;

    modport source (output valid, action, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink   (input valid, action, center_x, center_y, radius_x, radius_y,
                    output ready);
endinterface

// pixel channel: one pixel per transfer
interface elr_out_if
    import elr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [COORD_BITS:0]  pixel_x;
    logic signed [COORD_BITS:0]  pixel_y;
    logic                        last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

`default_nettype wire

// File: rtl/elr_front.sv
`default_nettype none

module elr_front
    import elr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    elr_in_if.sink    item,
    elr_in_if.source  cmd
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    logic                          act_q   [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0]  cx_q    [QUEUE_DEPTH];
    logic signed [COORD_BITS-1:0]  cy_q    [QUEUE_DEPTH];
    logic        [RADIUS_BITS-1:0] rx_q    [QUEUE_DEPTH];
    logic        [RADIUS_BITS-1:0] ry_q    [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    logic             is_start;

    // accept while there is room
    assign item.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign pop        = cmd.valid && cmd.ready;

    // a start keeps its centre and radii, an advance carries none
    assign is_start = (item.action == ACT_START);

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            act_q[wr_ptr_reg] <= item.action;
            cx_q[wr_ptr_reg]  <= is_start ? item.center_x : '0;
            cy_q[wr_ptr_reg]  <= is_start ? item.center_y : '0;
            rx_q[wr_ptr_reg]  <= is_start ? item.radius_x : '0;
            ry_q[wr_ptr_reg]  <= is_start ? item.radius_y : '0;
        end
    end

    // head of queue towards the step engine
    assign cmd.valid    = (count_reg != '0);
    assign cmd.action   = act_q[rd_ptr_reg];
    assign cmd.center_x = cx_q[rd_ptr_reg];
    assign cmd.center_y = cy_q[rd_ptr_reg];
    assign cmd.radius_x = rx_q[rd_ptr_reg];
    assign cmd.radius_y = ry_q[rd_ptr_reg];

endmodule

`default_nettype wire

// File: rtl/elr_back.sv
`default_nettype none

module elr_back
    import elr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    elr_in_if.sink     cmd,
    elr_out_if.source  pixel
);

    localparam int W_W    = RADIUS_BITS + 1;        // walk offsets
    localparam int MA_W   = 2 * RADIUS_BITS;        // squared radii
    localparam int MB_W   = 2 * RADIUS_BITS + 4;    // squared midpoint offsets
    localparam int PROD_W = MA_W + MB_W;
    localparam int DEC_W  = 4 * RADIUS_BITS + 8;
    localparam int PIX_W  = COORD_BITS + 1;
    localparam int SUM_W  = (PIX_W > W_W + 1) ? PIX_W : W_W + 1;

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic signed [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic        [RADIUS_BITS-1:0] rx_reg, ry_reg;
    logic        [MA_W-1:0]        a2_reg, b2_reg;
    logic        [W_W-1:0]         x_reg, y_reg;
    logic signed [DEC_W-1:0]       p_reg;
    logic signed [DEC_W-1:0]       hold_reg;
    logic        [PROD_W-1:0]      prod_reg;
    logic                          xinc_reg, ydec_reg, fin_reg;
    logic        [1:0]             cnt_reg;

    logic                          out_valid_reg;
    logic signed [PIX_W-1:0]       out_x_reg, out_y_reg;
    logic                          out_last_reg;

    logic                    pop, load_pix, walk_active, region_change, walk_done;
    logic [MA_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic signed [DEC_W-1:0] prod_s, a2_s, b2_s, inc_s;
    logic                    xi, yd;
    logic [SUM_W-1:0]        cx_ext, cy_ext, x_ext, y_ext, px_sum, py_sum;

    assign walk_active = (phase_reg == PH_REGION1) || (phase_reg == PH_REGION2);
    assign pop         = (state_reg == S_IDLE) && cmd.valid;
    assign load_pix    = (state_reg == S_EMIT) && (!out_valid_reg || pixel.ready);

    // signed views of the unsigned products and squares
    assign prod_s = signed'(DEC_W'(prod_reg));
    assign a2_s   = signed'(DEC_W'(a2_reg));
    assign b2_s   = signed'(DEC_W'(b2_reg));

    // region 1 ends once ry^2*x exceeds rx^2*y
    assign region_change = (phase_reg == PH_REGION1) && (hold_reg > prod_s);
    assign walk_done     = (phase_reg == PH_REGION2) && (y_reg == '0);

    // step direction from the current decision
    assign xi = (phase_reg == PH_REGION1) ? 1'b1 : (p_reg <= 0);
    assign yd = (phase_reg == PH_REGION1) ? (p_reg >= 0) : 1'b1;

    // decision increment, quarter scale
    always_comb
    begin
        inc_s = (phase_reg == PH_REGION2) ? a2_s : b2_s;
        if (xinc_reg)
        begin
            inc_s = inc_s + (hold_reg <<< 1);
        end
        if (ydec_reg)
        begin
            inc_s = inc_s - (prod_s <<< 1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.action == ACT_START)
                    begin
                        state_next = S_LA;
                    end
                    else if (walk_active)
                    begin
                        state_next = S_BX;
                    end
                end
            end
            S_LA:    state_next = S_LB;
            S_LB:    state_next = S_LC;
            S_LC:    state_next = S_LD;
            S_LD:    state_next = S_IDLE;
            S_BX:    state_next = S_AY;
            S_AY:    state_next = S_EVAL;
            S_EVAL:  state_next = region_change ? S_T1 : S_STEP;
            S_T1:    state_next = S_T2;
            S_T2:    state_next = S_T3;
            S_T3:    state_next = S_T4;
            S_T4:    state_next = S_T5;
            S_T5:    state_next = S_T6;
            S_T6:    state_next = S_STEP;
            S_STEP:  state_next = walk_done ? S_IDLE : S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_ACC;
            S_ACC:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (load_pix && (cnt_reg == LAST_PIXEL))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LA:
            begin
                mul_a = MA_W'(rx_reg);
                mul_b = MB_W'(rx_reg);
            end
            S_LB:
            begin
                mul_a = MA_W'(ry_reg);
                mul_b = MB_W'(ry_reg);
            end
            S_LC:
            begin
                mul_a = a2_reg;
                mul_b = MB_W'(ry_reg);
            end
            S_BX, S_M1:
            begin
                mul_a = b2_reg;
                mul_b = MB_W'(x_reg);
            end
            S_AY, S_M2:
            begin
                mul_a = a2_reg;
                mul_b = MB_W'(y_reg);
            end
            S_T1:
            begin
                mul_a = MA_W'({x_reg, 1'b1});
                mul_b = MB_W'({x_reg, 1'b1});
            end
            S_T2:
            begin
                mul_a = b2_reg;
                mul_b = prod_reg[MB_W-1:0];
            end
            S_T3:
            begin
                mul_a = MA_W'(y_reg - 1'b1);
                mul_b = MB_W'(y_reg - 1'b1);
            end
            S_T4:
            begin
                mul_a = a2_reg;
                mul_b = prod_reg[MB_W-1:0];
            end
            S_T5:
            begin
                mul_a = a2_reg;
                mul_b = MB_W'(b2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencer and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_LD:    phase_reg <= (ry_reg == '0) ? PH_IDLE : PH_REGION1;
                S_T6:    phase_reg <= PH_REGION2;
                S_STEP:
                begin
                    if (walk_done)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                S_ACC:
                begin
                    if (y_reg == '0)
                    begin
                        phase_reg <= PH_IDLE;
                    end
                end
                default: phase_reg <= phase_reg;
            endcase
        end
    end

    // walk datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            a2_reg <= '0;
            b2_reg <= '0;
            x_reg  <= '0;
            y_reg  <= '0;
            p_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && (cmd.action == ACT_START))
                    begin
                        cx_reg <= cmd.center_x;
                        cy_reg <= cmd.center_y;
                    end
                end
                S_LB:    a2_reg <= prod_reg[MA_W-1:0];
                S_LC:    b2_reg <= prod_reg[MA_W-1:0];
                S_LD:
                begin
                    p_reg <= (b2_s <<< 2) - (prod_s <<< 2) + a2_s;
                    x_reg <= '0;
                    y_reg <= W_W'(ry_reg);
                end
                S_T6:    p_reg <= hold_reg - (prod_s <<< 2);
                S_STEP:
                begin
                    if (!walk_done)
                    begin
                        x_reg <= x_reg + W_W'(xi);
                        y_reg <= y_reg - W_W'(yd);
                    end
                end
                S_ACC:   p_reg <= p_reg + (inc_s <<< 2);
                default: p_reg <= p_reg;
            endcase
        end
    end

    // working registers of one step
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rx_reg <= cmd.radius_x;
            ry_reg <= cmd.radius_y;
        end
        case (state_reg)
            S_LA, S_LB, S_LC, S_BX, S_AY, S_T1, S_T2, S_T3, S_T4, S_T5, S_M1, S_M2:
            begin
                prod_reg <= mul_p;
            end
            default: prod_reg <= prod_reg;
        endcase
        case (state_reg)
            S_AY, S_T3, S_M2: hold_reg <= prod_s;
            S_T5:             hold_reg <= hold_reg + (prod_s <<< 2);
            default:          hold_reg <= hold_reg;
        endcase
        if (state_reg == S_STEP)
        begin
            xinc_reg <= xi;
            ydec_reg <= yd;
        end
        if (state_reg == S_ACC)
        begin
            fin_reg <= (y_reg == '0);
        end
    end

    // mirrored pixel of the current point
    assign cx_ext = SUM_W'(cx_reg);
    assign cy_ext = SUM_W'(cy_reg);
    assign x_ext  = SUM_W'(x_reg);
    assign y_ext  = SUM_W'(y_reg);
    assign px_sum = cnt_reg[0] ? (cx_ext - x_ext) : (cx_ext + x_ext);
    assign py_sum = cnt_reg[1] ? (cy_ext - y_ext) : (cy_ext + y_ext);

    // pixel counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_ACC)
            begin
                cnt_reg <= '0;
            end
            else if (load_pix)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (load_pix)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pix)
        begin
            out_x_reg    <= px_sum[PIX_W-1:0];
            out_y_reg    <= py_sum[PIX_W-1:0];
            out_last_reg <= fin_reg && (cnt_reg == LAST_PIXEL);
        end
    end

    // outputs
    always_comb
    begin
        cmd.ready     = (state_reg == S_IDLE);
        pixel.valid   = out_valid_reg;
        pixel.pixel_x = out_x_reg;
        pixel.pixel_y = out_y_reg;
        pixel.last    = out_last_reg;
    end

endmodule

`default_nettype wire

// File: rtl/midpoint_ellipse_raster.sv
`default_nettype none

// channel  dir  transfer carries
// item     in   action, center_x, center_y, radius_x, radius_y
// pixel    out  pixel_x, pixel_y, last (four transfers per step)
//
// items go through a two-entry queue; the step engine takes one at a time
// a start runs the engine states LA, LB, LC and LD (three products on the shared multiplier)
// an advance runs BX, AY, EVAL, STEP, M1, M2 and ACC, then EMIT for each of the four pixels, with T1
// to T6 added on the step that enters region 2, its products all on the single shared multiplier
// reset clears queue, sequencer and walk; a stalled pixel sink holds the engine
// only once it has a new pixel to load

module midpoint_ellipse_raster
    import elr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    elr_in_if.sink     item,
    elr_out_if.source  pixel
);

    elr_in_if #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) cmd_q ();

    elr_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd_q)
    );

    elr_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_q),
        .pixel (pixel)
    );

endmodule

`default_nettype wire

// File: tb/sv/elr_raster_checker.sv
`timescale 1ns / 100ps

module elr_raster_checker
    import elr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    elr_in_if    item,
    elr_out_if   pixel,
    output int   fail_count,
    output int   pixels_pending
);

    localparam int CW        = COORD_BITS_DEF;
    localparam int RW        = RADIUS_BITS_DEF;

    typedef struct packed {
        logic signed [CW:0] px;
        logic signed [CW:0] py;
        logic               last;
    } pixel_rec_t;

    // walk state of the predictor, decision scaled by 4
    longint org_x, org_y;
    longint rx_sq, ry_sq;
    longint pos_x, pos_y;
    longint dec4;
    phase_t walk_phase;

    pixel_rec_t pixel_due[$];

    // one expected pixel, coordinates wrap to the output width
    function automatic void queue_pixel(input longint px, input longint py, input logic lst);
        pixel_rec_t r;
        r.px   = px[CW:0];
        r.py   = py[CW:0];
        r.last = lst;
        pixel_due = {pixel_due, r};
    endfunction

    // one start or advance item of the midpoint walk
    function automatic void trace_step(input logic act,
                                       input logic signed [CW-1:0] cx,
                                       input logic signed [CW-1:0] cy,
                                       input logic [RW-1:0] rx,
                                       input logic [RW-1:0] ry);
        longint x, y, p, a2, b2;
        logic   fin;
        if (act == ACT_START)
        begin
            org_x      = longint'(cx);
            org_y      = longint'(cy);
            rx_sq      = longint'(rx) * longint'(rx);
            ry_sq      = longint'(ry) * longint'(ry);
            pos_x      = 0;
            pos_y      = longint'(ry);
            dec4       = 4 * ry_sq - 4 * rx_sq * longint'(ry) + rx_sq;
            walk_phase = (ry == 0) ? PH_IDLE : PH_REGION1;
            return;
        end
        if (walk_phase != PH_REGION1 && walk_phase != PH_REGION2)
            return;

        a2 = rx_sq;
        b2 = ry_sq;
        x  = pos_x;
        y  = pos_y;
        p  = dec4;

        // leaving region 1: reload the decision at the region-2 midpoint
        if (walk_phase == PH_REGION1 && b2 * x > a2 * y)
        begin
            p = b2 * (2 * x + 1) * (2 * x + 1) + 4 * a2 * (y - 1) * (y - 1) - 4 * a2 * b2;
            walk_phase = PH_REGION2;
        end

        if (walk_phase == PH_REGION1)
        begin
            x++;
            if (p < 0)
                p += 4 * (2 * b2 * x + b2);
            else
            begin
                y--;
                p += 4 * (2 * b2 * x - 2 * a2 * y + b2);
            end
        end
        else
        begin
            if (y <= 0)
            begin
                walk_phase = PH_IDLE;
                return;
            end
            if (p <= 0)
            begin
                x++;
                y--;
                p += 4 * (2 * b2 * x - 2 * a2 * y + a2);
            end
            else
            begin
                y--;
                p += 4 * (a2 - 2 * a2 * y);
            end
        end

        pos_x = x;
        pos_y = y;
        dec4  = p;
        fin   = (y == 0);
        if (fin)
            walk_phase = PH_IDLE;

        // four mirrored pixels, the final one flagged on the closing step
        queue_pixel(org_x + x, org_y + y, 1'b0);
        queue_pixel(org_x - x, org_y + y, 1'b0);
        queue_pixel(org_x + x, org_y - y, 1'b0);
        queue_pixel(org_x - x, org_y - y, fin);
    endfunction

    // watch both channels, predict on item transfers, compare on pixel transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_rec_t want;
        if (!rst_n)
        begin
            org_x      = 0;
            org_y      = 0;
            rx_sq      = 0;
            ry_sq      = 0;
            pos_x      = 0;
            pos_y      = 0;
            dec4       = 0;
            walk_phase = PH_IDLE;
            pixel_due.delete();
            fail_count = 0;
            pixels_pending <= 0;
        end
        else
        begin
            if (item.valid && item.ready)
                trace_step(item.action, item.center_x, item.center_y,
                           item.radius_x, item.radius_y);

            if (pixel.valid && pixel.ready)
            begin
                if (pixel_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: pixel (%0d, %0d) last %0b with none expected",
                             $time, pixel.pixel_x, pixel.pixel_y, pixel.last);
                end
                else
                begin
                    want = pixel_due.pop_front();
                    if (pixel.pixel_x !== want.px || pixel.pixel_y !== want.py ||
                        pixel.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: pixel expected (%0d, %0d) last %0b, %s",
                                 $time, want.px, want.py, want.last, "got");
                        $display("%0t:   got (%0d, %0d) last %0b",
                                 $time, pixel.pixel_x, pixel.pixel_y, pixel.last);
                    end
                end
            end

            pixels_pending <= pixel_due.size();
        end
    end

endmodule

// File: tb/sv/tb_midpoint_ellipse_raster.sv
`timescale 1ns / 100ps

module tb_midpoint_ellipse_raster;
    import elr_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int RW          = RADIUS_BITS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 50000;
    localparam int TAIL_CYCLES = 60;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int n_fail;
    int n_pending;
    int n_items   = 0;
    int n_last    = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_req  = 1'b0;

    elr_in_if  item_ch ();
    elr_out_if pixel_ch ();

    midpoint_ellipse_raster u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .pixel (pixel_ch)
    );

    elr_raster_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .pixel          (pixel_ch),
        .fail_count     (n_fail),
        .pixels_pending (n_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #3_000_000;
        $display("[midpoint_ellipse_raster] ERROR");
        $finish;
    end

    // completed ellipses, used to end a walk early
    always @(posedge clk)
    begin
        if (pixel_ch.valid && pixel_ch.ready && pixel_ch.last)
            n_last <= n_last + 1;
    end

    // pixel sink: random stalls, or one long hold-off on request
    initial
    begin
        pixel_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pixel_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                pixel_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one item transfer, with random gaps carrying junk fields
    task automatic put_item(input logic act,
                            input logic signed [CW-1:0] cx,
                            input logic signed [CW-1:0] cy,
                            input logic [RW-1:0] rx,
                            input logic [RW-1:0] ry);
        while ($urandom_range(99) < send_idle)
        begin
            item_ch.valid    <= 1'b0;
            item_ch.action   <= 1'($urandom);
            item_ch.center_x <= CW'($urandom);
            item_ch.center_y <= CW'($urandom);
            item_ch.radius_x <= RW'($urandom);
            item_ch.radius_y <= RW'($urandom);
            @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.action   <= act;
        item_ch.center_x <= cx;
        item_ch.center_y <= cy;
        item_ch.radius_x <= rx;
        item_ch.radius_y <= ry;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        n_items++;
    endtask

    // advance until the ellipse closes or the step budget runs out
    task automatic walk(input int max_steps);
        int seen;
        int k;
        seen = n_last;
        for (k = 0; k < max_steps && n_last == seen; k++)
            put_item(ACT_ADVANCE, CW'($urandom), CW'($urandom), RW'($urandom), RW'($urandom));
    endtask

    // stop offering and wait for every outstanding pixel
    task automatic drain();
        int g;
        item_ch.valid <= 1'b0;
        @(posedge clk);
        for (g = 0; g < DRAIN_LIMIT && n_pending != 0; g++)
            @(posedge clk);
    endtask

    // mostly complete small walks, some cut short, some large partial walks, stray advances
    task automatic random_walks(input int stop_at);
        int             pick;
        int             steps;
        logic [RW-1:0]  rx;
        logic [RW-1:0]  ry;
        while (n_items < stop_at)
        begin
            pick = int'($urandom_range(99));
            if (pick < 8)
                put_item(ACT_ADVANCE, CW'($urandom), CW'($urandom),
                         RW'($urandom), RW'($urandom));
            else
            begin
                if (pick < 25)
                begin
                    rx    = RW'($urandom);
                    ry    = RW'($urandom);
                    steps = int'($urandom_range(1, 6));
                end
                else
                begin
                    rx    = RW'($urandom_range(0, 12));
                    ry    = RW'($urandom_range(0, 12));
                    steps = int'(rx) + int'(ry) + 2;
                    if ($urandom_range(9) == 0)
                        steps = int'($urandom_range(0, steps));
                end
                put_item(ACT_START, CW'($urandom), CW'($urandom), rx, ry);
                walk(steps);
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        item_ch.valid    <= 1'b0;
        item_ch.action   <= ACT_START;
        item_ch.center_x <= '0;
        item_ch.center_y <= '0;
        item_ch.radius_x <= '0;
        item_ch.radius_y <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle advance, zero radii, extremes of centre and radii
        put_item(ACT_ADVANCE, 0, 0, 0, 0);
        put_item(ACT_START, 0, 0, 0, 0);
        put_item(ACT_ADVANCE, -1, -1, '1, '1);
        put_item(ACT_START, -2048, 2047, 0, 3);
        walk(4);
        put_item(ACT_START, 2047, -2048, 4, 2);
        walk(8);
        put_item(ACT_START, 0, 0, 1, 1);
        walk(2);
        put_item(ACT_START, -1, -1, 1023, 1023);
        walk(3);
        put_item(ACT_START, 5, -5, 1, 1023);
        walk(2);
        put_item(ACT_START, -5, 5, 1023, 1);
        walk(2);
        drain();

        // random: slow sender, mostly stalled sink
        send_idle = 35;
        recv_idle = 82;
        random_walks(n_items + 60);
        drain();

        // random: mostly idle sender, lightly stalled sink
        send_idle = 82;
        recv_idle = 35;
        random_walks(n_items + 60);
        drain();

        // random: no gaps, opening with a long sink hold-off to back up the input
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 1'b1;
        random_walks(n_items + 60);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_fail == 0 && n_pending == 0)
            $display("[midpoint_ellipse_raster] OK");
        else
            $display("[midpoint_ellipse_raster] ERROR");
        $finish;
    end

endmodule
